/* hw/rtl/tpss_pkg.sv */
// Shared types and constants of the time-phased slot scheduler.
// Used by the channel interfaces, the divider and the top level; depends on nothing.
package tpss_pkg;

  localparam int DATA_W         = 32;
  localparam int PORT_W         = 3;
  localparam int MAX_SLOTS_DEF  = 16;
  localparam int PORT_COUNT_DEF = 8;

  typedef enum logic [1:0] {
    KIND_REGISTERED = 2'd0,
    KIND_REJECTED   = 2'd1,
    KIND_DISPATCH   = 2'd2,
    KIND_MISSED     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_CYCLE = 3'd0,
    ERR_FULL     = 3'd1,
    ERR_ORDER    = 3'd2,
    ERR_BEYOND   = 3'd3,
    ERR_CTX_SMALL = 3'd4,
    ERR_OVERFLOW = 3'd5
  } err_t;

  // One row of the slot table.
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] length;
    logic [DATA_W-1:0] context_val;
    logic              windowed;
  } slot_entry_t;

endpackage

/* hw/rtl/tpss_if.sv */
// Valid/ready channel interfaces for scheduler items and result items.
// Depends on tpss_pkg for field widths.
interface tpss_req_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [tpss_pkg::PORT_W-1:0]     entry_port;
  logic [tpss_pkg::DATA_W-1:0]     entry_start;
  logic                            start_given;
  logic [tpss_pkg::DATA_W-1:0]     entry_length;
  logic [tpss_pkg::DATA_W-1:0]     context_window;
  logic                            context_given;

  modport source (output valid, action, entry_port, entry_start, start_given, entry_length,
                  context_window, context_given, input ready);
  modport sink (input valid, action, entry_port, entry_start, start_given, entry_length,
                context_window, context_given, output ready);
endinterface

interface tpss_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [2:0]                      error_code;
  logic [tpss_pkg::PORT_W-1:0]     port;
  logic [tpss_pkg::DATA_W-1:0]     context_res;
  logic [tpss_pkg::DATA_W-1:0]     slot_start;
  logic [tpss_pkg::DATA_W-1:0]     slot_length;
  logic [tpss_pkg::DATA_W-1:0]     overrun;

  modport source (output valid, kind, error_code, port, context_res, slot_start,
                  slot_length, overrun, input ready);
  modport sink (input valid, kind, error_code, port, context_res, slot_start,
                slot_length, overrun, output ready);
endinterface

/* hw/rtl/tpss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/tpss_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the scheduler.
// Depends on tpss_pkg for the data width.
module tpss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tpss_pkg::DATA_W-1:0] dividend,
  input  logic [tpss_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [tpss_pkg::DATA_W-1:0] quotient,
  output logic [tpss_pkg::DATA_W-1:0] remainder
);
  localparam int W  = tpss_pkg::DATA_W;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  dvsr;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {remainder, quotient[W-1]};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= CW'(W);
        dvsr      <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (diff[W]) begin
          remainder <= shifted[W-1:0];
        end else begin
          remainder <= diff[W-1:0];
        end
        quotient <= {quotient[W-2:0], ~diff[W]};
        count    <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* hw/rtl/time_phased_slot_scheduler.sv */
// Cyclic time-slot scheduler. Register items append a slot to a table of MAX_SLOTS rows held
// in a RAM; tick items advance time and finish or dispatch slots. One item is handled at a
// time under a sequencer, so req.ready is high only while the block is idle. A registration
// reads the previous row when the table is not empty; a sequential context adds a same-port
// search over the table rows (one RAM read each), and a windowed context adds instead a pass
// through the shared 32-step divider and one multiply. A rejection ends sooner. A tick adds
// a division for each remainder it needs (cycle rollover, windowed context). The result
// register lets the next item in while a result waits; a new result that finds it still
// full holds the sequencer until the receiver takes the earlier one.
module time_phased_slot_scheduler #(
  parameter int MAX_SLOTS  = tpss_pkg::MAX_SLOTS_DEF,
  parameter int PORT_COUNT = tpss_pkg::PORT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tpss_pkg::DATA_W-1:0] cfg_data,
  tpss_req_if.sink                    req,
  tpss_rsp_if.source                  rsp
);
  localparam int W     = tpss_pkg::DATA_W;
  localparam int PW    = tpss_pkg::PORT_W;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int EW    = $bits(tpss_pkg::slot_entry_t);

  typedef enum logic [4:0] {
    S_IDLE, S_R_START, S_R_PREV, S_R_PREVD, S_R_CHECK, S_R_DIV, S_R_MUL, S_R_OVF,
    S_R_SADDR, S_R_SWAIT, S_R_SCHK, S_R_WRITE, S_T_START, S_T_ROLL, S_T_FCHK,
    S_T_FWAIT, S_T_FIN, S_T_DCHK, S_T_DWAIT, S_T_DUSE, S_T_DDIV, S_EMIT
  } state_t;

  state_t state;

  logic [W-1:0]        cycle_len;
  logic [CNT_W-1:0]    used_count;
  logic [CNT_W-1:0]    current_slot;
  logic [CNT_W-1:0]    sidx;
  logic [W-1:0]        tick_count;
  logic [W-1:0]        rollover_product;
  logic [W-1:0]        last_start_tick;
  logic [W-1:0]        last_cycle_tick;
  logic [W-1:0]        cycle_counter;
  logic [MAX_SLOTS-1:0] slot_running;

  // Latched input item.
  logic                action;
  logic [PW-1:0]       eport;
  logic [W-1:0]        estart;
  logic                sgiven;
  logic [W-1:0]        elen;
  logic [W-1:0]        ewin;
  logic                cgiven;

  logic [W-1:0]        start_w;
  logic [W-1:0]        ctx_w;
  logic [2*W-1:0]      prod;

  // Staged result.
  tpss_pkg::kind_t     r_kind;
  tpss_pkg::err_t      r_err;
  logic [PW-1:0]       r_port;
  logic [W-1:0]        r_ctx;
  logic [W-1:0]        r_start;
  logic [W-1:0]        r_len;
  logic [W-1:0]        r_over;

  logic                o_valid;
  logic [1:0]          o_kind;
  logic [2:0]          o_err;
  logic [PW-1:0]       o_port;
  logic [W-1:0]        o_ctx;
  logic [W-1:0]        o_start;
  logic [W-1:0]        o_len;
  logic [W-1:0]        o_over;

  logic [IDX_W-1:0]    rd_addr;
  tpss_pkg::slot_entry_t rd_entry;
  tpss_pkg::slot_entry_t wr_entry;
  logic [EW-1:0]       rd_bits;
  logic                ram_we;

  logic                div_start;
  logic [W-1:0]        div_a;
  logic [W-1:0]        div_b;
  logic                div_done;
  logic [W-1:0]        div_q;
  logic [W-1:0]        div_r;

  logic [CNT_W-1:0]    prev_cnt;
  logic [IDX_W-1:0]    used_idx;
  logic [IDX_W-1:0]    cur_idx;
  logic [W:0]          prev_end;
  logic [W:0]          fit_end;
  logic [W-1:0]        now_next;
  logic [W-1:0]        exec_ticks;
  logic                cur_valid;

  assign prev_cnt   = used_count - CNT_W'(1);
  assign used_idx   = used_count[IDX_W-1:0];
  assign cur_idx    = current_slot[IDX_W-1:0];
  assign rd_entry   = tpss_pkg::slot_entry_t'(rd_bits);
  assign prev_end   = {1'b0, rd_entry.start} + {1'b0, rd_entry.length};
  assign fit_end    = {1'b0, start_w} + {1'b0, elen};
  assign now_next   = tick_count + W'(1);
  assign exec_ticks = tick_count - last_start_tick;
  assign cur_valid  = current_slot < used_count;
  assign ram_we     = (state == S_R_WRITE);
  assign wr_entry   = '{port: eport, start: start_w, length: elen, context_val: ctx_w,
                        windowed: cgiven};

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = o_valid;
  assign rsp.kind        = o_kind;
  assign rsp.error_code  = o_err;
  assign rsp.port        = o_port;
  assign rsp.context_res = o_ctx;
  assign rsp.slot_start  = o_start;
  assign rsp.slot_length = o_len;
  assign rsp.overrun     = o_over;

  tpss_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used_idx),
    .wdata (EW'(wr_entry)),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  tpss_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_len <= '0;
    end else if (cfg_we) begin
      cycle_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      used_count       <= '0;
      current_slot     <= '0;
      tick_count       <= '1;
      rollover_product <= W'(1);
      last_start_tick  <= '0;
      last_cycle_tick  <= '0;
      cycle_counter    <= '0;
      slot_running     <= '0;
      o_valid          <= 1'b0;
      div_start        <= 1'b0;
    end else begin
      // The emit state refills the output register itself.
      if (rsp.ready && state != S_EMIT) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            action <= req.action;
            eport  <= req.entry_port;
            estart <= req.entry_start;
            sgiven <= req.start_given;
            elen   <= req.entry_length;
            ewin   <= req.context_window;
            cgiven <= req.context_given;
            r_kind  <= tpss_pkg::KIND_REJECTED;
            r_err   <= tpss_pkg::ERR_NO_CYCLE;
            r_port  <= req.entry_port;
            r_ctx   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_over  <= '0;
            state   <= req.action ? S_T_START : S_R_START;
          end
        end
        S_R_START: begin
          if (cycle_len == '0) begin
            r_err <= tpss_pkg::ERR_NO_CYCLE;
            state <= S_EMIT;
          end else if (used_count >= CNT_W'(MAX_SLOTS)) begin
            r_err <= tpss_pkg::ERR_FULL;
            state <= S_EMIT;
          end else if (used_count != '0) begin
            rd_addr <= prev_cnt[IDX_W-1:0];
            state   <= S_R_PREV;
          end else begin
            start_w <= sgiven ? estart : '0;
            state   <= S_R_CHECK;
          end
        end
        S_R_PREV: state <= S_R_PREVD;
        S_R_PREVD: begin
          if (sgiven) begin
            if ({1'b0, estart} < prev_end || estart <= rd_entry.start) begin
              r_err <= tpss_pkg::ERR_ORDER;
              state <= S_EMIT;
            end else begin
              start_w <= estart;
              state   <= S_R_CHECK;
            end
          end else begin
            start_w <= prev_end[W-1:0];
            state   <= S_R_CHECK;
          end
        end
        S_R_CHECK: begin
          if ({{(7-PW){1'b0}}, eport} >= 7'(PORT_COUNT) || fit_end > {1'b0, cycle_len}) begin
            r_err <= tpss_pkg::ERR_BEYOND;
            state <= S_EMIT;
          end else if (cgiven) begin
            if (ewin <= cycle_len) begin
              r_err <= tpss_pkg::ERR_CTX_SMALL;
              state <= S_EMIT;
            end else begin
              div_a     <= ewin;
              div_b     <= cycle_len;
              div_start <= 1'b1;
              state     <= S_R_DIV;
            end
          end else begin
            ctx_w <= '0;
            sidx  <= '0;
            state <= S_R_SADDR;
          end
        end
        S_R_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            ctx_w <= div_q;
            state <= S_R_MUL;
          end
        end
        S_R_MUL: begin
          prod  <= rollover_product * ctx_w;
          state <= S_R_OVF;
        end
        S_R_OVF: begin
          if (rollover_product == '0 || prod[2*W-1:W] != '0) begin
            r_err <= tpss_pkg::ERR_OVERFLOW;
            state <= S_EMIT;
          end else begin
            rollover_product <= prod[W-1:0];
            state            <= S_R_WRITE;
          end
        end
        S_R_SADDR: begin
          if (sidx < used_count) begin
            rd_addr <= sidx[IDX_W-1:0];
            state   <= S_R_SWAIT;
          end else begin
            state <= S_R_WRITE;
          end
        end
        S_R_SWAIT: state <= S_R_SCHK;
        S_R_SCHK: begin
          // The last matching row wins, so later rows simply overwrite.
          if (rd_entry.port == eport) begin
            ctx_w <= rd_entry.context_val + W'(1);
          end
          sidx  <= sidx + CNT_W'(1);
          state <= S_R_SADDR;
        end
        S_R_WRITE: begin
          slot_running[used_idx] <= 1'b0;
          used_count <= used_count + CNT_W'(1);
          r_kind     <= tpss_pkg::KIND_REGISTERED;
          r_err      <= tpss_pkg::ERR_NO_CYCLE;
          r_ctx      <= ctx_w;
          r_start    <= start_w;
          state      <= S_EMIT;
        end
        S_T_START: begin
          tick_count <= now_next;
          if (now_next - last_cycle_tick >= cycle_len && current_slot == used_count) begin
            last_cycle_tick <= now_next;
            current_slot    <= '0;
            if (rollover_product != '0) begin
              div_a     <= cycle_counter + W'(1);
              div_b     <= rollover_product;
              div_start <= 1'b1;
              state     <= S_T_ROLL;
            end else begin
              cycle_counter <= '0;
              state         <= S_T_FCHK;
            end
          end else begin
            state <= S_T_FCHK;
          end
        end
        S_T_ROLL: begin
          div_start <= 1'b0;
          if (div_done) begin
            cycle_counter <= div_r;
            state         <= S_T_FCHK;
          end
        end
        S_T_FCHK: begin
          if (cur_valid && slot_running[cur_idx]) begin
            rd_addr <= cur_idx;
            state   <= S_T_FWAIT;
          end else begin
            state <= S_T_DCHK;
          end
        end
        S_T_FWAIT: state <= S_T_FIN;
        S_T_FIN: begin
          slot_running[cur_idx] <= 1'b0;
          current_slot <= current_slot + CNT_W'(1);
          if (exec_ticks > rd_entry.length) begin
            r_kind  <= tpss_pkg::KIND_MISSED;
            r_err   <= tpss_pkg::ERR_NO_CYCLE;
            r_port  <= rd_entry.port;
            r_start <= rd_entry.start;
            r_len   <= rd_entry.length;
            r_over  <= exec_ticks - rd_entry.length;
            state   <= S_EMIT;
          end else begin
            state <= S_T_DCHK;
          end
        end
        S_T_DCHK: begin
          if (cur_valid && !slot_running[cur_idx]) begin
            rd_addr <= cur_idx;
            state   <= S_T_DWAIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_T_DWAIT: state <= S_T_DUSE;
        S_T_DUSE: begin
          if (rd_entry.start <= tick_count - last_cycle_tick) begin
            slot_running[cur_idx] <= 1'b1;
            last_start_tick <= tick_count;
            r_kind <= tpss_pkg::KIND_DISPATCH;
            r_err  <= tpss_pkg::ERR_NO_CYCLE;
            r_port <= rd_entry.port;
            if (rd_entry.windowed && rd_entry.context_val != '0) begin
              div_a     <= cycle_counter;
              div_b     <= rd_entry.context_val;
              div_start <= 1'b1;
              state     <= S_T_DDIV;
            end else begin
              r_ctx <= rd_entry.windowed ? '0 : rd_entry.context_val;
              state <= S_EMIT;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_T_DDIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            r_ctx <= div_r;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_kind  <= r_kind;
            o_err   <= r_err;
            o_port  <= r_port;
            o_ctx   <= r_ctx;
            o_start <= r_start;
            o_len   <= r_len;
            o_over  <= r_over;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(MAX_SLOTS))
    else $error("slot table count exceeds its depth");

  a_current_bound: assert property (@(posedge clk) disable iff (rst)
    current_slot <= used_count)
    else $error("current slot points past the table");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> used_count < CNT_W'(MAX_SLOTS))
    else $error("table write with no free row");

  a_one_running: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_running) <= 1)
    else $error("more than one slot marked running");

  a_div_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_R_DIV || state == S_T_ROLL || state == S_T_DDIV))
    else $error("divider finished while nobody waits for it");

  // Only tick items may enter the tick path.
  a_action_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_START) |-> action)
    else $error("tick path entered for a registration item");

endmodule
